>>> rtl/hrp_pkg.sv
`default_nettype none

package hrp_pkg;

    localparam int NAME_LIMIT_DEF = 63;
    localparam int FIFO_DEPTH     = 4;

    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CH_NL      = 8'h0a;
    localparam logic [7:0]  CH_ZERO    = 8'h30;
    localparam logic [7:0]  CH_NINE    = 8'h39;
    localparam logic [30:0] VALUE_MAX  = 31'h7fff_ffff;

    typedef enum logic [2:0] {
        PH_NAME1 = 3'd0,
        PH_N1A   = 3'd1,
        PH_N1B   = 3'd2,
        PH_NAME2 = 3'd3,
        PH_N2A   = 3'd4,
        PH_N2B   = 3'd5,
        PH_SKIP  = 3'd6,
        PH_HALT  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        EV_NAME1 = 3'd0,
        EV_NAME2 = 3'd1,
        EV_NUM   = 3'd2,
        EV_DONE  = 3'd3,
        EV_END   = 3'd4,
        EV_ERR   = 3'd5
    } event_t;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NAME_LONG = 3'd1;
    localparam logic [2:0] ERR_NAME1_END = 3'd2;
    localparam logic [2:0] ERR_NUM_END   = 3'd3;
    localparam logic [2:0] ERR_NAME2_END = 3'd4;
    localparam logic [2:0] ERR_LAST_END  = 3'd5;

    typedef struct packed {
        logic [7:0] byte_req;
        logic       is_eof;
    } rec_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [1:0]  field_index;
        logic [30:0] value;
        logic [2:0]  error_code;
        logic        last;
    } evt_t;

    typedef struct packed {
        logic [1:0] count;
        evt_t       first;
        evt_t       second;
    } push_t;

    function automatic evt_t make_evt(event_t ev, logic [1:0] idx, logic [30:0] val,
                                      logic [2:0] err, logic lst);
        evt_t e;
        e.event_res   = ev;
        e.field_index = idx;
        e.value       = val;
        e.error_code  = err;
        e.last        = lst;
        return e;
    endfunction

endpackage

`default_nettype wire

>>> rtl/homology_record_parser.sv
// homology_record_parser: byte-stream parser for tab-separated records of the form
// name, number, number, name, number, number
// input channel rec_valid / rec_stall / rec: one byte or end-of-input mark per item
// output channel evt_valid / evt_stall / evt: tagged name characters, numbers,
// record done, end and error items; last marks the final item of one input
// an accepted input item is held in an item register; once the queue has room its
// results are written into the output queue, whose head drives the output port
// throughput: one input item per cycle while the queue has room; an item giving two
// results (the last number of a record) uses two output slots of a four-entry output
// queue, so the sustained rate is set by that queue and the consumer draining it
// input is stalled while a held item waits and the queue holds more than two items
// a stalled output holds its item; inputs arrive until the queue has over two items
// reset clears the parse state to the first name field and empties the queue
// after end of input or an error every further item repeats that result
`default_nettype none

module homology_record_parser #(
    parameter int NAME_LIMIT = hrp_pkg::NAME_LIMIT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rec_valid,
    output logic               rec_stall,
    input  wire hrp_pkg::rec_t rec,
    output logic               evt_valid,
    input  wire logic          evt_stall,
    output hrp_pkg::evt_t      evt
);
    import hrp_pkg::*;

    push_t push;
    logic  room;

    hrp_parse #(
        .NAME_LIMIT (NAME_LIMIT)
    ) u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec       (rec),
        .room      (room),
        .push      (push)
    );

    hrp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule

`default_nettype wire

>>> rtl/hrp_parse.sv
`default_nettype none

module hrp_parse #(
    parameter int NAME_LIMIT = hrp_pkg::NAME_LIMIT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rec_valid,
    output logic               rec_stall,
    input  wire hrp_pkg::rec_t rec,
    input  wire logic          room,
    output hrp_pkg::push_t     push
);
    import hrp_pkg::*;

    localparam int CW = $clog2(NAME_LIMIT + 1);

    logic        item_valid_reg, item_valid_next;
    rec_t        item_reg;
    phase_t      phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [30:0] acc_reg, acc_next;

    logic        proc;
    logic        accept;
    logic [7:0]  ch;
    logic        eof;
    logic        is_digit;
    logic [3:0]  digit;
    logic [34:0] prod;
    logic [30:0] acc_sat;
    logic [1:0]  idx;
    evt_t        r0, r1;
    logic [1:0]  n;

    assign proc      = item_valid_reg && room;
    assign rec_stall = item_valid_reg && !room;
    assign accept    = rec_valid && !rec_stall;
    assign ch        = item_reg.byte_req;
    assign eof       = item_reg.is_eof;
    assign is_digit  = !eof && (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit     = 4'(ch - CH_ZERO);
    assign prod      = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 35'(digit);
    assign acc_sat   = (prod > 35'(VALUE_MAX)) ? VALUE_MAX : prod[30:0];

    always_comb
    begin
        unique case (phase_reg)
            PH_N1A:  idx = 2'd0;
            PH_N1B:  idx = 2'd1;
            PH_N2A:  idx = 2'd2;
            default: idx = 2'd3;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        n          = 2'd0;
        r0         = make_evt(EV_END, 2'd0, 31'd0, ERR_NONE, 1'b1);
        r1         = make_evt(EV_DONE, 2'd0, 31'd0, ERR_NONE, 1'b1);
        unique case (phase_reg)
            PH_NAME1, PH_NAME2:
            begin
                n = 2'd1;
                if (eof)
                begin
                    phase_next = PH_HALT;
                    if (phase_reg == PH_NAME2)
                    begin
                        acc_next = 31'(ERR_NAME2_END);
                        r0 = make_evt(EV_ERR, 2'd0, 31'd0, ERR_NAME2_END, 1'b1);
                    end
                    else
                    begin
                        acc_next = 31'd0;
                    end
                end
                else if (ch == CH_TAB)
                begin
                    n          = 2'd0;
                    phase_next = (phase_reg == PH_NAME1) ? PH_N1A : PH_N2A;
                    acc_next   = 31'd0;
                end
                else if (ch == CH_NL)
                begin
                    phase_next = PH_HALT;
                    if (phase_reg == PH_NAME1)
                    begin
                        acc_next = 31'(ERR_NAME1_END);
                        r0 = make_evt(EV_ERR, 2'd0, 31'd0, ERR_NAME1_END, 1'b1);
                    end
                    else
                    begin
                        acc_next = 31'(ERR_NAME2_END);
                        r0 = make_evt(EV_ERR, 2'd0, 31'd0, ERR_NAME2_END, 1'b1);
                    end
                end
                else if (cnt_reg >= CW'(NAME_LIMIT))
                begin
                    phase_next = PH_HALT;
                    acc_next   = 31'(ERR_NAME_LONG);
                    r0 = make_evt(EV_ERR, 2'd0, 31'd0, ERR_NAME_LONG, 1'b1);
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                    r0 = make_evt((phase_reg == PH_NAME1) ? EV_NAME1 : EV_NAME2,
                                  2'd0, {23'd0, ch}, ERR_NONE, 1'b1);
                end
            end
            PH_N1A, PH_N1B, PH_N2A:
            begin
                if (is_digit)
                begin
                    acc_next = acc_sat;
                end
                else if (eof || ch != CH_TAB)
                begin
                    n          = 2'd1;
                    phase_next = PH_HALT;
                    acc_next   = 31'(ERR_NUM_END);
                    r0 = make_evt(EV_ERR, 2'd0, 31'd0, ERR_NUM_END, 1'b1);
                end
                else
                begin
                    n          = 2'd1;
                    r0         = make_evt(EV_NUM, idx, acc_reg, ERR_NONE, 1'b1);
                    phase_next = phase_t'(phase_reg + 3'd1);
                    cnt_next   = '0;
                    acc_next   = 31'd0;
                end
            end
            PH_N2B:
            begin
                if (is_digit)
                begin
                    acc_next = acc_sat;
                end
                else if (eof || (ch != CH_TAB && ch != CH_NL))
                begin
                    n          = 2'd1;
                    phase_next = PH_HALT;
                    acc_next   = 31'(ERR_LAST_END);
                    r0 = make_evt(EV_ERR, 2'd0, 31'd0, ERR_LAST_END, 1'b1);
                end
                else
                begin
                    n          = 2'd2;
                    r0         = make_evt(EV_NUM, idx, acc_reg, ERR_NONE, 1'b0);
                    phase_next = (ch == CH_NL) ? PH_NAME1 : PH_SKIP;
                    cnt_next   = '0;
                    acc_next   = 31'd0;
                end
            end
            PH_SKIP:
            begin
                if (eof)
                begin
                    n          = 2'd1;
                    phase_next = PH_HALT;
                    acc_next   = 31'd0;
                end
                else if (ch == CH_NL)
                begin
                    phase_next = PH_NAME1;
                    cnt_next   = '0;
                end
            end
            PH_HALT:
            begin
                n = 2'd1;
                if (acc_reg != 31'd0)
                begin
                    r0 = make_evt(EV_ERR, 2'd0, 31'd0, acc_reg[2:0], 1'b1);
                end
            end
        endcase
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (proc)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_NAME1;
            cnt_reg        <= '0;
            acc_reg        <= 31'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            if (proc)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                acc_reg   <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= rec;
        end
    end

    always_comb
    begin
        push.count  = proc ? n : 2'd0;
        push.first  = r0;
        push.second = r1;
    end

endmodule

`default_nettype wire

>>> rtl/hrp_out_fifo.sv
`default_nettype none

module hrp_out_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire hrp_pkg::push_t push,
    output logic                room,
    output logic                evt_valid,
    input  wire logic           evt_stall,
    output hrp_pkg::evt_t       evt
);
    import hrp_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    evt_t          mem [FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          pop;

    assign room      = count_reg <= (AW + 1)'(FIFO_DEPTH - 2);
    assign evt_valid = count_reg != '0;
    assign evt       = mem[rd_ptr_reg];
    assign pop       = evt_valid && !evt_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.count);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW + 1)'(push.count) - (AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + AW'(1)] <= push.second;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/homology_record_parser_tb.sv
`default_nettype none

module homology_record_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hrp_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int TARGET_ITEMS = 1300;
    localparam int IDLE_PCT = 34;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 160;
    localparam int QUIET_FROM = 600;
    localparam int QUIET_TO = 800;
    localparam int DRAIN_AT = 900;

    typedef struct {
        rec_t data;
        bit   drain_first;
    } feed_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic rec_valid = 1'b0;
    logic rec_stall;
    rec_t rec = '0;
    logic evt_valid;
    logic evt_stall = 1'b0;
    evt_t evt;

    feed_t byte_q[$];
    evt_t pending_events[$];

    phase_t parse_ph = PH_NAME1;
    logic [5:0] name_len = '0;
    logic [30:0] num_acc = '0;

    int cycle_cnt = 0;
    int rec_count = 0;
    int result_cnt = 0;
    int number_cnt = 0;
    int record_cnt = 0;
    int mismatches = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit in_fire = 1'b0;
    string end_kind = "";

    homology_record_parser u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .rec_valid(rec_valid),
        .rec_stall(rec_stall),
        .rec(rec),
        .evt_valid(evt_valid),
        .evt_stall(evt_stall),
        .evt(evt)
    );

    always #2 clk = ~clk;

    // expected result store
    task automatic push_evt(input event_t ev, input logic [1:0] idx, input logic [30:0] val,
                            input logic [2:0] err, input logic lst);
        evt_t e;
        e.event_res   = ev;
        e.field_index = idx;
        e.value       = val;
        e.error_code  = err;
        e.last        = lst;
        pending_events.push_back(e);
    endtask

    task automatic halt_with(input logic [2:0] code);
        parse_ph = PH_HALT;
        num_acc = {28'd0, code};
        push_evt(EV_ERR, 2'd0, '0, code, 1'b1);
    endtask

    task automatic predict_events(input rec_t r);
        logic [34:0] wide;
        logic [1:0] idx;
        case (parse_ph)
            PH_NAME1, PH_NAME2:
            begin
                if (r.is_eof)
                begin
                    if (parse_ph == PH_NAME2)
                        halt_with(ERR_NAME2_END);
                    else
                    begin
                        parse_ph = PH_HALT;
                        num_acc = '0;
                        push_evt(EV_END, 2'd0, '0, ERR_NONE, 1'b1);
                    end
                end
                else if (r.byte_req == CH_TAB)
                begin
                    parse_ph = phase_t'(parse_ph + 3'd1);
                    num_acc = '0;
                end
                else if (r.byte_req == CH_NL)
                    halt_with((parse_ph == PH_NAME1) ? ERR_NAME1_END : ERR_NAME2_END);
                else if (name_len >= 6'(NAME_LIMIT_DEF))
                    halt_with(ERR_NAME_LONG);
                else
                begin
                    name_len = name_len + 6'd1;
                    push_evt((parse_ph == PH_NAME1) ? EV_NAME1 : EV_NAME2, 2'd0,
                             {23'd0, r.byte_req}, ERR_NONE, 1'b1);
                end
            end
            PH_N1A, PH_N1B, PH_N2A, PH_N2B:
            begin
                case (parse_ph)
                    PH_N1A: idx = 2'd0;
                    PH_N1B: idx = 2'd1;
                    PH_N2A: idx = 2'd2;
                    default: idx = 2'd3;
                endcase
                if (!r.is_eof && r.byte_req >= CH_ZERO && r.byte_req <= CH_NINE)
                begin
                    wide = {4'd0, num_acc} * 35'd10 + {27'd0, r.byte_req - CH_ZERO};
                    num_acc = (wide > {4'd0, VALUE_MAX}) ? VALUE_MAX : wide[30:0];
                end
                else if (parse_ph != PH_N2B)
                begin
                    if (r.is_eof || r.byte_req != CH_TAB)
                        halt_with(ERR_NUM_END);
                    else
                    begin
                        push_evt(EV_NUM, idx, num_acc, ERR_NONE, 1'b1);
                        parse_ph = phase_t'(parse_ph + 3'd1);
                        name_len = '0;
                        num_acc = '0;
                    end
                end
                else if (r.is_eof || (r.byte_req != CH_TAB && r.byte_req != CH_NL))
                    halt_with(ERR_LAST_END);
                else
                begin
                    push_evt(EV_NUM, idx, num_acc, ERR_NONE, 1'b0);
                    push_evt(EV_DONE, 2'd0, '0, ERR_NONE, 1'b1);
                    parse_ph = (r.byte_req == CH_NL) ? PH_NAME1 : PH_SKIP;
                    name_len = '0;
                    num_acc = '0;
                end
            end
            PH_SKIP:
            begin
                if (r.is_eof)
                begin
                    parse_ph = PH_HALT;
                    num_acc = '0;
                    push_evt(EV_END, 2'd0, '0, ERR_NONE, 1'b1);
                end
                else if (r.byte_req == CH_NL)
                begin
                    parse_ph = PH_NAME1;
                    name_len = '0;
                end
            end
            default:
            begin
                if (num_acc == '0)
                    push_evt(EV_END, 2'd0, '0, ERR_NONE, 1'b1);
                else
                    push_evt(EV_ERR, 2'd0, '0, num_acc[2:0], 1'b1);
            end
        endcase
    endtask

    task automatic check_event(input evt_t got);
        evt_t want;
        if (pending_events.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: ev %0d idx %0d val %0d err %0d last %0d",
                         got.event_res, got.field_index, got.value, got.error_code, got.last);
        end
        else
        begin
            want = pending_events.pop_front();
            result_cnt++;
            if (want.event_res == EV_NUM)
                number_cnt++;
            if (want.event_res == EV_DONE)
                record_cnt++;
            if (got.event_res !== want.event_res || got.field_index !== want.field_index ||
                got.value !== want.value || got.error_code !== want.error_code ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at result %0d: expected ev %0d idx %0d val %0d err %0d last %0d, got ev %0d idx %0d val %0d err %0d last %0d",
                             result_cnt, want.event_res, want.field_index, want.value,
                             want.error_code, want.last, got.event_res, got.field_index,
                             got.value, got.error_code, got.last);
            end
        end
    endtask

    // stream building
    task automatic put_item(input logic [7:0] b, input logic eof);
        feed_t f;
        f.data.byte_req = b;
        f.data.is_eof = eof;
        f.drain_first = 1'b0;
        byte_q.push_back(f);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_item(s[i], 1'b0);
    endtask

    task automatic put_name_len(input int n);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_TAB || b == CH_NL);
            put_item(b, 1'b0);
        end
    endtask

    task automatic put_name();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            put_name_len(NAME_LIMIT_DEF);
        else if (r == 1)
            put_name_len(0);
        else if (r < 4)
            put_name_len($urandom_range(9, NAME_LIMIT_DEF - 1));
        else
            put_name_len($urandom_range(1, 8));
    endtask

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++)
            put_item(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    task automatic put_number();
        case ($urandom_range(0, 19))
            0: ;
            1: put_text("2147483647");
            2: put_text("2147483648");
            3: put_digits($urandom_range(11, 14));
            4:
            begin
                put_text("000");
                put_digits($urandom_range(1, 3));
            end
            default: put_digits($urandom_range(1, 6));
        endcase
    endtask

    // fields of a record up to the start of the next field
    task automatic put_head(input int stages);
        if (stages > 0)
        begin
            put_name();
            put_item(CH_TAB, 1'b0);
        end
        if (stages > 1)
        begin
            put_number();
            put_item(CH_TAB, 1'b0);
        end
        if (stages > 2)
        begin
            put_number();
            put_item(CH_TAB, 1'b0);
        end
        if (stages > 3)
        begin
            put_name();
            put_item(CH_TAB, 1'b0);
        end
        if (stages > 4)
        begin
            put_number();
            put_item(CH_TAB, 1'b0);
        end
    endtask

    task automatic put_skip_tail();
        logic [7:0] b;
        repeat ($urandom_range(0, 6))
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_NL);
            put_item(b, 1'b0);
        end
    endtask

    function automatic logic [7:0] bad_byte(input bit nl_ok);
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_TAB || (!nl_ok && b == CH_NL));
        return b;
    endfunction

    task automatic put_record();
        put_head(5);
        put_number();
        if ($urandom_range(0, 9) < 6)
            put_item(CH_NL, 1'b0);
        else
        begin
            put_item(CH_TAB, 1'b0);
            put_skip_tail();
            put_item(CH_NL, 1'b0);
        end
    endtask

    // the stream ends in one terminal case, chosen per run
    task automatic put_ending();
        int stage;
        case ($urandom_range(0, 7))
            0:
            begin
                end_kind = "end of input in first name";
                put_name_len($urandom_range(0, 5));
                put_item(8'($urandom_range(0, 255)), 1'b1);
            end
            1:
            begin
                end_kind = "first name too long";
                put_name_len(NAME_LIMIT_DEF + 1);
            end
            2:
            begin
                end_kind = "newline in first name";
                put_name_len($urandom_range(0, 5));
                put_item(CH_NL, 1'b0);
            end
            3:
            begin
                end_kind = "bad number terminator";
                case ($urandom_range(0, 2))
                    0: stage = 1;
                    1: stage = 2;
                    default: stage = 4;
                endcase
                put_head(stage);
                put_number();
                if ($urandom_range(0, 3) == 0)
                    put_item(8'($urandom_range(0, 255)), 1'b1);
                else
                    put_item(bad_byte(1'b1), 1'b0);
            end
            4:
            begin
                end_kind = "second name cut short";
                put_head(3);
                put_name_len($urandom_range(0, 5));
                if ($urandom_range(0, 1) == 0)
                    put_item(CH_NL, 1'b0);
                else
                    put_item(8'($urandom_range(0, 255)), 1'b1);
            end
            5:
            begin
                end_kind = "bad last number terminator";
                put_head(5);
                put_number();
                if ($urandom_range(0, 3) == 0)
                    put_item(8'($urandom_range(0, 255)), 1'b1);
                else
                    put_item(bad_byte(1'b0), 1'b0);
            end
            6:
            begin
                end_kind = "end of input while skipping";
                put_head(5);
                put_number();
                put_item(CH_TAB, 1'b0);
                put_skip_tail();
                put_item(8'($urandom_range(0, 255)), 1'b1);
            end
            default:
            begin
                end_kind = "second name too long";
                put_head(3);
                put_name_len(NAME_LIMIT_DEF + 1);
            end
        endcase
        repeat (6)
            put_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // input side: sample the handshake, predict, check results
    always @(posedge clk)
    begin
        cycle_cnt++;
        in_fire = rst_n && rec_valid && !rec_stall;
        if (in_fire)
        begin
            rec_count++;
            predict_events(rec);
        end
        if (rst_n && evt_valid && !evt_stall)
            check_event(evt);
    end

    // byte driver
    always @(negedge clk)
    begin : drive_rec
        bit gap;
        bit quiet;
        quiet = (rec_count >= QUIET_FROM && rec_count < QUIET_TO) || hold_left != 0;
        gap = !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        if (rst_n && !(rec_valid && !in_fire))
        begin
            if (byte_q.size() != 0 && !gap &&
                !(byte_q[0].drain_first && pending_events.size() != 0))
            begin
                rec <= byte_q[0].data;
                rec_valid <= 1'b1;
                void'(byte_q.pop_front());
            end
            else
                rec_valid <= 1'b0;
        end
    end

    // result receiver stall, with one long hold-off
    always @(negedge clk)
    begin : drive_stall
        bit quiet;
        quiet = rec_count >= QUIET_FROM && rec_count < QUIET_TO;
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                evt_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && rec_count >= HOLD_AT)
            begin
                evt_stall <= 1'b1;
                hold_left <= HOLD_CYCLES - 1;
                hold_done <= 1'b1;
            end
            else
                evt_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin
        // empty fields everywhere, then extreme bytes, empty numbers and the skip phase
        put_text("\t\t\t\t\t\n");
        put_item(8'hff, 1'b0);
        put_text("\t7\t\t");
        put_item(8'h00, 1'b0);
        put_text("\t\t9\tzz\n");
        while (byte_q.size() < TARGET_ITEMS)
            put_record();
        byte_q[DRAIN_AT].drain_first = 1'b1;
        put_ending();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || rec_valid || pending_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        mismatches += pending_events.size();

        $display("covered %0d input items and %0d results: %0d numbers, %0d records",
                 rec_count, result_cnt, number_cnt, record_cnt);
        $display("stream ended by: %s", end_kind);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
